[design/dfp_pkg.sv]
// dfp_pkg: constants, status codes and helper functions for the date field parser
// no dependencies; used by date_field_parser
`default_nettype none

package dfp_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 16;
    localparam int ACC_W  = NUM_W + 4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [NUM_W-1:0] RUN_MAX      = 16'hFFFF;
    localparam logic [NUM_W-1:0] YEAR_MIN     = 16'd1900;
    localparam logic [NUM_W-1:0] YEAR_MAX     = 16'd2078;
    localparam logic [NUM_W-1:0] CENTURY_BASE = 16'd1900;
    localparam logic [NUM_W-1:0] SHORT_LIMIT  = 16'd100;
    localparam logic [NUM_W-1:0] MONTHS       = 16'd12;

    // divisibility by 25: multiply by the inverse of 25 mod 2^16,
    // the value is a multiple exactly when the product is at most 65535 / 25
    localparam logic [NUM_W-1:0] INV25       = 16'd23593;
    localparam logic [NUM_W-1:0] DIV25_LIMIT = 16'd2621;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TWO_DIGIT = 3'd1,
        ST_NO_DIGITS = 3'd2,
        ST_BAD_YEAR  = 3'd3,
        ST_BAD_MONTH = 3'd4,
        ST_BAD_DAY   = 3'd5
    } t_status;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // n * 10 + digit, saturating
    function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] n,
                                                    input logic [CHAR_W-1:0] c);
        logic [ACC_W-1:0] v;
        v = {1'b0, n, 3'b000} + {3'b000, n, 1'b0} + {16'd0, c[3:0]};
        return (v > {4'd0, RUN_MAX}) ? RUN_MAX : v[NUM_W-1:0];
    endfunction

    function automatic logic [4:0] days_in_month(input logic [NUM_W-1:0] y,
                                                 input logic [NUM_W-1:0] m);
        logic [NUM_W-1:0] p;
        logic             div25;
        logic             leap;
        p     = y * INV25;
        div25 = (p <= DIV25_LIMIT);
        // leap: multiple of 4, and not a century unless a multiple of 400
        leap  = (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
        if (m == 16'd2) begin
            return leap ? 5'd29 : 5'd28;
        end
        if (m == 16'd4 || m == 16'd6 || m == 16'd9 || m == 16'd11) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

endpackage

`default_nettype wire

[design/date_field_parser.sv]
// date_field_parser: character stream in, one parsed date result per field out
// depends on dfp_pkg for character codes, status codes and date helpers
//
//  channel  dir  tdata                              tuser
//  s_axis   in   [7:0] char_in                      [0] start_field
//  m_axis   out  [15:0] year [19:16] month          [2:0] status
//                [24:20] day, [31:25] zero
//
// one character beat per cycle while s_axis_tready is high; each beat is parsed in the cycle it is taken
// a result is registered and shows on m_axis the cycle after the character
// that ends the field; the date checks sit between state and result register
// synchronous active-low reset returns the parser to idle and empties the result
// s_axis_tready is low only while a result waits and m_axis_tready is low
`default_nettype none

module date_field_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic [0:0]  s_axis_tuser,   // [0] start_field
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] year, [19:16] month, [24:20] day
    output logic [2:0]       m_axis_tuser    // [2:0] status
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_THIRD  = 2'd3
    } t_phase;

    t_phase                          r_phase, n_phase, e_phase;
    logic [dfp_pkg::NUM_W-1:0]       r_first, n_first, e_first;
    logic [dfp_pkg::NUM_W-1:0]       r_second, n_second, e_second;
    logic [dfp_pkg::NUM_W-1:0]       r_third, n_third, e_third;
    logic [dfp_pkg::CHAR_W-1:0]      r_sep, n_sep, e_sep;
    logic                            r_seen, n_seen, e_seen;

    logic                            r_out_valid;
    logic [dfp_pkg::NUM_W-1:0]       r_year;
    logic [3:0]                      r_month;
    logic [4:0]                      r_day;
    dfp_pkg::t_status                r_status;

    logic                            in_fire;
    logic [dfp_pkg::CHAR_W-1:0]      c;
    logic                            start;
    logic                            dig;
    logic                            blank;
    logic                            emit;
    dfp_pkg::t_status                emit_st;

    logic [dfp_pkg::NUM_W-1:0]       fin_y, fin_m, fin_d;
    logic                            fin_two, fin_year_ok;
    logic [4:0]                      fin_dim;
    dfp_pkg::t_status                fin_st;

    assign c             = s_axis_tdata;
    assign start         = s_axis_tuser[0];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign dig           = dfp_pkg::is_digit(c);
    assign blank         = (c == dfp_pkg::CH_SPACE) || (c == dfp_pkg::CH_TAB);

    // field checks on the stored runs, used when the third run ends
    always_comb begin
        fin_two     = 1'b0;
        fin_year_ok = 1'b1;
        if (r_first < dfp_pkg::SHORT_LIMIT) begin
            // month / day / year order
            fin_m = r_first;
            fin_d = r_second;
            if (r_third < dfp_pkg::SHORT_LIMIT) begin
                fin_y   = r_third + dfp_pkg::CENTURY_BASE;
                fin_two = 1'b1;
            end else begin
                fin_y = r_third;
            end
        end else begin
            fin_y       = r_first;
            fin_m       = r_second;
            fin_d       = r_third;
            fin_year_ok = (r_first >= dfp_pkg::YEAR_MIN) && (r_first <= dfp_pkg::YEAR_MAX);
        end
        fin_dim = dfp_pkg::days_in_month(fin_y, fin_m);
        if (!fin_year_ok) begin
            fin_st = dfp_pkg::ST_BAD_YEAR;
        end else if (fin_m < 16'd1 || fin_m > dfp_pkg::MONTHS) begin
            fin_st = dfp_pkg::ST_BAD_MONTH;
        end else if (fin_d < 16'd1 || fin_d > {11'd0, fin_dim}) begin
            fin_st = dfp_pkg::ST_BAD_DAY;
        end else if (fin_two) begin
            fin_st = dfp_pkg::ST_TWO_DIGIT;
        end else begin
            fin_st = dfp_pkg::ST_OK;
        end
    end

    // per-character parse step
    always_comb begin
        e_phase  = start ? PH_FIRST : r_phase;
        e_first  = start ? '0 : r_first;
        e_second = start ? '0 : r_second;
        e_third  = start ? '0 : r_third;
        e_sep    = start ? '0 : r_sep;
        e_seen   = start ? 1'b0 : r_seen;

        n_phase  = e_phase;
        n_first  = e_first;
        n_second = e_second;
        n_third  = e_third;
        n_sep    = e_sep;
        n_seen   = e_seen;
        emit     = 1'b0;
        emit_st  = dfp_pkg::ST_NO_DIGITS;

        case (e_phase)
            PH_FIRST: begin
                if (!e_seen) begin
                    if (blank) begin
                        n_seen = 1'b0;
                    end else if (!dig) begin
                        emit = 1'b1;
                    end else begin
                        n_first = dfp_pkg::accumulate('0, c);
                        n_seen  = 1'b1;
                    end
                end else if (dig) begin
                    n_first = dfp_pkg::accumulate(e_first, c);
                end else if (c == dfp_pkg::CH_DASH || c == dfp_pkg::CH_SLASH) begin
                    n_sep   = c;
                    n_phase = PH_SECOND;
                    n_seen  = 1'b0;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_SECOND: begin
                if (dig) begin
                    n_second = dfp_pkg::accumulate(e_seen ? e_second : '0, c);
                    n_seen   = 1'b1;
                end else if (e_seen && c == e_sep) begin
                    n_phase = PH_THIRD;
                    n_seen  = 1'b0;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_THIRD: begin
                if (dig) begin
                    n_third = dfp_pkg::accumulate(e_seen ? e_third : '0, c);
                    n_seen  = 1'b1;
                end else if (!e_seen) begin
                    emit = 1'b1;
                end else begin
                    emit    = 1'b1;
                    emit_st = fin_st;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                r_phase  <= n_phase;
                r_first  <= n_first;
                r_second <= n_second;
                r_third  <= n_third;
                r_sep    <= n_sep;
                r_seen   <= n_seen;
                if (emit) begin
                    r_status    <= emit_st;
                    // error results carry an all-zero date
                    if (emit_st == dfp_pkg::ST_OK || emit_st == dfp_pkg::ST_TWO_DIGIT) begin
                        r_year  <= fin_y;
                        r_month <= fin_m[3:0];
                        r_day   <= fin_d[4:0];
                    end else begin
                        r_year  <= '0;
                        r_month <= '0;
                        r_day   <= '0;
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_day, r_month, r_year};
    assign m_axis_tuser  = r_status;

`ifndef SYNTHESIS
    a_err_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != dfp_pkg::ST_OK
            && m_axis_tuser != dfp_pkg::ST_TWO_DIGIT) |-> (m_axis_tdata == 32'd0))
        else $error("error result carries a nonzero date");

    a_ok_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == dfp_pkg::ST_OK
            || m_axis_tuser == dfp_pkg::ST_TWO_DIGIT))
        |-> (m_axis_tdata[19:16] >= 4'd1 && m_axis_tdata[19:16] <= 4'd12
            && m_axis_tdata[24:20] != 5'd0))
        else $error("accepted date has month or day out of range");

    a_two_digit_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == dfp_pkg::ST_TWO_DIGIT)
        |-> (m_axis_tdata[15:0] >= 16'd1900 && m_axis_tdata[15:0] <= 16'd1999))
        else $error("two digit year not placed in the 1900s");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

[verif/tb_date_field_parser.sv]
`timescale 1ns / 1ps
// tb_date_field_parser: self-checking testbench for the date field parser
// feeds character beats, predicts each parsed date in a local scanner, checks m_axis
// depends on dfp_pkg and date_field_parser

module tb_date_field_parser;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_FIRST,
        SCAN_SECOND,
        SCAN_THIRD
    } t_scan;

    typedef struct {
        logic [15:0]      year;
        logic [3:0]       month;
        logic [4:0]       day;
        dfp_pkg::t_status status;
    } t_date;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_in
    logic [0:0]  s_axis_tuser = 1'b0;   // [0] start_field
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [15:0] year, [19:16] month, [24:20] day
    logic [2:0]  m_axis_tuser;          // [2:0] status

    // scanner state mirrored from the parser
    t_scan       scan = SCAN_IDLE;
    logic [15:0] run_a = '0;
    logic [15:0] run_b = '0;
    logic [15:0] run_c = '0;
    logic [7:0]  sep_char = '0;
    bit          have_digit = 1'b0;

    t_date       dates_due[$];
    logic [7:0]  field_buf[$];
    int          errors = 0;
    int          items_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    date_field_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------- date prediction ----------------

    function automatic logic [15:0] grow_run(input logic [15:0] n, input logic [7:0] c);
        int v;
        v = int'(n) * 10 + int'(c) - int'(dfp_pkg::CH_ZERO);
        return (v > 65535) ? dfp_pkg::RUN_MAX : 16'(v);
    endfunction

    function automatic int month_len(input int y, input int m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == 2) begin
            return leap ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit emit_date(output t_date r, input int y, input int m, input int d,
                                     input dfp_pkg::t_status st);
        bit keep;
        keep     = (st == dfp_pkg::ST_OK) || (st == dfp_pkg::ST_TWO_DIGIT);
        r.year   = keep ? 16'(y) : 16'd0;
        r.month  = keep ? 4'(m) : 4'd0;
        r.day    = keep ? 5'(d) : 5'd0;
        r.status = st;
        scan     = SCAN_IDLE;
        return 1'b1;
    endfunction

    function automatic bit close_field(output t_date r);
        int               y;
        int               m;
        int               d;
        dfp_pkg::t_status st;
        st = dfp_pkg::ST_OK;
        if (run_a < dfp_pkg::SHORT_LIMIT) begin
            // month, day, year order
            m = run_a;
            d = run_b;
            y = run_c;
            if (y < dfp_pkg::SHORT_LIMIT) begin
                y  = y + dfp_pkg::CENTURY_BASE;
                st = dfp_pkg::ST_TWO_DIGIT;
            end
        end else begin
            y = run_a;
            m = run_b;
            d = run_c;
            if (y < dfp_pkg::YEAR_MIN || y > dfp_pkg::YEAR_MAX) begin
                return emit_date(r, 0, 0, 0, dfp_pkg::ST_BAD_YEAR);
            end
        end
        if (m < 1 || m > dfp_pkg::MONTHS) begin
            return emit_date(r, 0, 0, 0, dfp_pkg::ST_BAD_MONTH);
        end
        if (d < 1 || d > month_len(y, m)) begin
            return emit_date(r, 0, 0, 0, dfp_pkg::ST_BAD_DAY);
        end
        return emit_date(r, y, m, d, st);
    endfunction

    // returns 1 when this character closes a field
    function automatic bit parse_char(input logic [7:0] c, input bit restart, output t_date r);
        bit num;
        r.year   = '0;
        r.month  = '0;
        r.day    = '0;
        r.status = dfp_pkg::ST_OK;
        if (restart) begin
            scan       = SCAN_FIRST;
            run_a      = '0;
            run_b      = '0;
            run_c      = '0;
            sep_char   = '0;
            have_digit = 1'b0;
        end
        num = (c >= dfp_pkg::CH_ZERO) && (c <= dfp_pkg::CH_NINE);
        case (scan)
            SCAN_FIRST: begin
                if (!have_digit) begin
                    if (c == dfp_pkg::CH_SPACE || c == dfp_pkg::CH_TAB) begin
                        return 1'b0;
                    end
                    if (!num) begin
                        return emit_date(r, 0, 0, 0, dfp_pkg::ST_NO_DIGITS);
                    end
                    run_a      = grow_run(16'd0, c);
                    have_digit = 1'b1;
                    return 1'b0;
                end
                if (num) begin
                    run_a = grow_run(run_a, c);
                    return 1'b0;
                end
                if (c == dfp_pkg::CH_DASH || c == dfp_pkg::CH_SLASH) begin
                    sep_char   = c;
                    scan       = SCAN_SECOND;
                    have_digit = 1'b0;
                    return 1'b0;
                end
                return emit_date(r, 0, 0, 0, dfp_pkg::ST_NO_DIGITS);
            end
            SCAN_SECOND: begin
                if (num) begin
                    run_b      = grow_run(have_digit ? run_b : 16'd0, c);
                    have_digit = 1'b1;
                    return 1'b0;
                end
                if (have_digit && c == sep_char) begin
                    scan       = SCAN_THIRD;
                    have_digit = 1'b0;
                    return 1'b0;
                end
                return emit_date(r, 0, 0, 0, dfp_pkg::ST_NO_DIGITS);
            end
            SCAN_THIRD: begin
                if (num) begin
                    run_c      = grow_run(have_digit ? run_c : 16'd0, c);
                    have_digit = 1'b1;
                    return 1'b0;
                end
                if (!have_digit) begin
                    return emit_date(r, 0, 0, 0, dfp_pkg::ST_NO_DIGITS);
                end
                return close_field(r);
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_date want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (dates_due.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = dates_due.pop_front();
                check_field("year", want.year, m_axis_tdata[15:0]);
                check_field("month", want.month, m_axis_tdata[19:16]);
                check_field("day", want.day, m_axis_tdata[24:20]);
                check_field("pad", 0, m_axis_tdata[31:25]);
                check_field("status", want.status, m_axis_tuser);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_char(input logic [7:0] c, input bit restart);
        t_date r;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 8'($urandom_range(255));
            s_axis_tuser  = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tuser  = restart;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (parse_char(c, restart, r)) begin
            dates_due.push_back(r);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_text(input string s, input bit restart);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], restart && k == 0);
        end
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (dates_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] any_non_digit();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c >= dfp_pkg::CH_ZERO && c <= dfp_pkg::CH_NINE) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic push_run(input int v);
        string s;
        if ($urandom_range(19) == 0) begin
            // long run, drives the saturation
            repeat ($urandom_range(6, 9)) begin
                field_buf.push_back(8'(dfp_pkg::CH_ZERO + $urandom_range(9)));
            end
        end else begin
            s = $sformatf("%0d", v);
            if ($urandom_range(7) == 0) begin
                repeat ($urandom_range(1, 2)) field_buf.push_back(dfp_pkg::CH_ZERO);
            end
            for (int k = 0; k < s.len(); k++) begin
                field_buf.push_back(s[k]);
            end
        end
    endtask

    task automatic send_date_field();
        logic [7:0] sep;
        logic [7:0] sep2;
        bit         ymd;
        int         kind;
        int         drop;
        int         yr;
        int         mo;
        int         dy;
        field_buf.delete();
        kind = $urandom_range(19);
        ymd  = $urandom_range(1);
        case ($urandom_range(11))
            0:       mo = 0;
            1:       mo = $urandom_range(13, ymd ? 20 : 99);
            default: mo = $urandom_range(1, 12);
        endcase
        case ($urandom_range(9))
            0:       dy = 0;
            1:       dy = $urandom_range(32, 99);
            2, 3:    dy = $urandom_range(28, 31);
            default: dy = $urandom_range(1, 28);
        endcase
        if (ymd) begin
            case ($urandom_range(9))
                0:       yr = $urandom_range(100, 1899);
                1:       yr = $urandom_range(2079, 9999);
                2:       yr = $urandom_range(1) ? 1899 : 2079;
                3:       yr = $urandom_range(1) ? 1900 : ($urandom_range(1) ? 2000 : 2078);
                default: yr = $urandom_range(1900, 2078);
            endcase
        end else begin
            case ($urandom_range(7))
                0, 1, 2: yr = $urandom_range(0, 99);
                3:       yr = $urandom_range(100, 65535);
                4:       yr = $urandom_range(1) ? 2100 : ($urandom_range(1) ? 2400 : 2000);
                default: yr = $urandom_range(1950, 2050);
            endcase
        end
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) begin
            field_buf.push_back($urandom_range(1) ? dfp_pkg::CH_SPACE : dfp_pkg::CH_TAB);
        end
        // broken shapes: a missing run, a second separator that differs, an odd separator
        drop = (kind == 0) ? $urandom_range(1, 3) : 0;
        sep  = $urandom_range(1) ? dfp_pkg::CH_DASH : dfp_pkg::CH_SLASH;
        sep2 = (kind == 1) ? ((sep == dfp_pkg::CH_DASH) ? dfp_pkg::CH_SLASH : dfp_pkg::CH_DASH)
                           : sep;
        if (kind == 2) begin
            sep = any_non_digit();
        end
        if (drop != 1) push_run(ymd ? yr : mo);
        field_buf.push_back(sep);
        if (drop != 2) push_run(ymd ? mo : dy);
        field_buf.push_back(sep2);
        if (drop != 3) push_run(ymd ? dy : yr);
        // no terminator now and then: the next field restarts this one
        if ($urandom_range(9) != 0) begin
            field_buf.push_back(any_non_digit());
        end
        foreach (field_buf[k]) begin
            send_char(field_buf[k], k == 0);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_ignored_while_idle();
        send_text("7", 1'b0);
        send_text("/", 1'b0);
    endtask

    task automatic test_directed_dates();
        send_text(" 2000-2-29;", 1'b1);   // blank skip, leap century
        send_text("13/1/5 ", 1'b1);       // bad month beats the assumed century
        send_text("99999-1-1.", 1'b1);    // saturated run, year out of range
        send_text("8-9/", 1'b1);          // second separator differs
        settle();
    endtask

    task automatic test_restart_mid_field();
        send_text("4-", 1'b1);
        send_text("a", 1'b1);             // restart, then no digit
        settle();
    endtask

    task automatic test_random_stream(input int gap, input int stall, input int n);
        int stop_at;
        gap_pct   = gap;
        stall_pct = stall;
        stop_at   = items_sent + n;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                send_date_field();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_char(8'($urandom_range(255)), $urandom_range(99) < 30);
                end
            end
        end
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ignored_while_idle();
        test_directed_dates();
        test_restart_mid_field();
        test_random_stream(0, 0, 150);
        test_random_stream(62, 0, 150);
        test_random_stream(0, 62, 150);
        test_random_stream(20, 20, 150);

        if (errors == 0 && dates_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
